/* rtl/dtq_pkg.sv */
package dtq_pkg;

    localparam int unsigned TableDepth = 16;
    localparam int unsigned IdxW       = $clog2(TableDepth);
    localparam int unsigned CntW       = $clog2(TableDepth + 1);
    localparam int unsigned MaxFire    = 16;
    localparam int unsigned FireW      = $clog2(MaxFire + 1);

    localparam logic [2:0] REQ_POST_NOW     = 3'd0;
    localparam logic [2:0] REQ_POST_DELAYED = 3'd1;
    localparam logic [2:0] REQ_POST_PERIOD  = 3'd2;
    localparam logic [2:0] REQ_DELETE       = 3'd3;
    localparam logic [2:0] REQ_TICK         = 3'd4;

    localparam logic [2:0] ST_POSTED    = 3'd0;
    localparam logic [2:0] ST_DELETED   = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_FIRED     = 3'd4;
    localparam logic [2:0] ST_NONE_DUE  = 3'd5;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [19:0] delay_value;
        logic [30:0] delete_id;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [30:0] assigned_id;
        logic [30:0] fired_id;
        logic        last;
    } t_rsp;

    typedef struct packed {
        logic [30:0] id;
        logic [31:0] deadline;
        logic [19:0] period;
        logic        rep;
    } t_entry;

endpackage

/* rtl/deadline_timer_queue.sv */
// channel | dir | valid   | stall   | payload
// request | in  | i_valid | o_stall | i_req (dtq_pkg::t_req)
// result  | out | o_valid | i_stall | o_rsp (dtq_pkg::t_rsp)
// a post scans the table one slot per cycle (up to 16 slots), then shifts in the new entry
// delete scans up to 16 slots; a tick fires one entry per result beat, a periodic
// entry adding its own reinsertion scan and shift before the next beat
// reset clears fill count, time and id counter; entries need no clearing
// a result waits in the output register while i_stall is high; no new request
// is taken until the last result beat of the current one has left
module deadline_timer_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  dtq_pkg::t_req   i_req,
    output logic            o_valid,
    input  logic            i_stall,
    output dtq_pkg::t_rsp   o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SHIFT, S_DEL, S_TICK
    } t_state;

    t_state                      r_state;
    dtq_pkg::t_entry             r_tab [dtq_pkg::TableDepth];
    logic [dtq_pkg::CntW-1:0]    r_fill;
    logic [31:0]                 r_now;
    logic [30:0]                 r_idc;
    dtq_pkg::t_req               r_req;
    dtq_pkg::t_entry             r_new;
    logic                        r_after;
    logic [dtq_pkg::CntW-1:0]    r_pos;
    logic [dtq_pkg::FireW-1:0]   r_nfire;
    logic                        r_tick;
    logic                        r_valid;
    dtq_pkg::t_rsp               r_rsp;

    logic [dtq_pkg::IdxW-1:0]    w_pi;
    logic [31:0]                 w_ke;
    logic [31:0]                 w_kn;
    logic                        w_stop;
    logic [31:0]                 w_k0;
    logic [31:0]                 w_k1;
    logic                        w_due;
    logic                        w_last;
    logic                        w_ld;
    logic [19:0]                 w_per;
    logic [30:0]                 w_nid;

    assign w_pi   = r_pos[dtq_pkg::IdxW-1:0];
    assign w_ke   = (r_tab[w_pi].deadline - r_now) ^ 32'h8000_0000;
    assign w_kn   = (r_new.deadline - r_now) ^ 32'h8000_0000;
    assign w_stop = r_after ? (w_ke > w_kn) : (w_ke >= w_kn);
    assign w_k0   = (r_tab[0].deadline - r_now) ^ 32'h8000_0000;
    assign w_k1   = (r_tab[1].deadline - r_now) ^ 32'h8000_0000;
    assign w_due  = (r_fill != '0) && (w_k0 <= 32'h8000_0000)
                    && (r_nfire < dtq_pkg::FireW'(dtq_pkg::MaxFire));
    // set when no further entry is due after this one fires or the fire limit is reached
    assign w_last = !((r_fill > dtq_pkg::CntW'(1)) && (w_k1 <= 32'h8000_0000)
                    && (r_nfire < dtq_pkg::FireW'(dtq_pkg::MaxFire - 1)));
    assign w_ld   = (r_state == S_TICK) && (!r_valid || !i_stall)
                    && (w_due || r_nfire == '0);
    assign w_per  = (i_req.delay_value == 20'd0) ? 20'd1 : i_req.delay_value;
    assign w_nid  = (r_idc == 31'h7FFF_FFFF) ? 31'd1 : r_idc + 31'd1;

    assign o_stall = (r_state != S_IDLE) || r_valid;
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_now   <= '0;
            r_idc   <= '0;
            r_valid <= 1'b0;
            r_tick  <= 1'b0;
        end else begin
            if (r_valid && !i_stall && !w_ld) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_req   <= i_req;
                        r_pos   <= '0;
                        r_nfire <= '0;
                        r_tick  <= 1'b0;
                        unique case (i_req.req_type) inside
                            dtq_pkg::REQ_POST_NOW, dtq_pkg::REQ_POST_DELAYED,
                            dtq_pkg::REQ_POST_PERIOD: begin
                                if (r_fill >= dtq_pkg::CntW'(dtq_pkg::TableDepth)) begin
                                    r_rsp   <= '{dtq_pkg::ST_FULL, 31'd0, 31'd0, 1'b1};
                                    r_valid <= 1'b1;
                                end else begin
                                    r_idc      <= w_nid;
                                    r_after    <= 1'b1;
                                    r_new.id   <= w_nid;
                                    r_new.rep  <= (i_req.req_type == dtq_pkg::REQ_POST_PERIOD);
                                    if (i_req.req_type == dtq_pkg::REQ_POST_NOW) begin
                                        r_new.deadline <= r_now;
                                        r_new.period   <= '0;
                                    end else if (i_req.req_type == dtq_pkg::REQ_POST_DELAYED) begin
                                        r_new.deadline <= r_now + 32'(i_req.delay_value);
                                        r_new.period   <= '0;
                                    end else begin
                                        r_new.deadline <= r_now + 32'(w_per);
                                        r_new.period   <= w_per;
                                    end
                                    r_state <= S_SCAN;
                                end
                            end
                            dtq_pkg::REQ_DELETE: r_state <= S_DEL;
                            dtq_pkg::REQ_TICK: begin
                                r_now   <= r_now + 32'd1;
                                r_tick  <= 1'b1;
                                r_state <= S_TICK;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_pos == r_fill || w_stop) begin
                        r_state <= S_SHIFT;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_SHIFT: begin
                    for (int i = 1; i < dtq_pkg::TableDepth; i++) begin
                        if (dtq_pkg::CntW'(i) > r_pos && dtq_pkg::CntW'(i) <= r_fill) begin
                            r_tab[i] <= r_tab[i-1];
                        end
                    end
                    r_tab[w_pi] <= r_new;
                    r_fill      <= r_fill + 1'b1;
                    if (r_tick) begin
                        r_state <= r_rsp.last ? S_IDLE : S_TICK;
                    end else begin
                        r_rsp   <= '{dtq_pkg::ST_POSTED, r_new.id, 31'd0, 1'b1};
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_DEL: begin
                    if (r_pos == r_fill) begin
                        r_rsp   <= '{dtq_pkg::ST_NOT_FOUND, 31'd0, 31'd0, 1'b1};
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_tab[w_pi].id == r_req.delete_id) begin
                        for (int i = 0; i < dtq_pkg::TableDepth - 1; i++) begin
                            if (dtq_pkg::CntW'(i) >= r_pos) begin
                                r_tab[i] <= r_tab[i+1];
                            end
                        end
                        r_fill  <= r_fill - 1'b1;
                        r_rsp   <= '{dtq_pkg::ST_DELETED, 31'd0, 31'd0, 1'b1};
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_TICK: begin
                    if (!r_valid || !i_stall) begin
                        if (w_due) begin
                            for (int i = 0; i < dtq_pkg::TableDepth - 1; i++) begin
                                r_tab[i] <= r_tab[i+1];
                            end
                            r_fill  <= r_fill - 1'b1;
                            r_nfire <= r_nfire + 1'b1;
                            r_rsp   <= '{dtq_pkg::ST_FIRED, 31'd0, r_tab[0].id, w_last};
                            r_valid <= 1'b1;
                            if (r_tab[0].rep) begin
                                r_new   <= '{r_tab[0].id, r_now + 32'(r_tab[0].period),
                                             r_tab[0].period, 1'b1};
                                r_after <= 1'b0;
                                r_pos   <= '0;
                                r_state <= S_SCAN;
                            end else if (w_last) begin
                                r_state <= S_IDLE;
                            end
                        end else if (r_nfire == '0) begin
                            r_rsp   <= '{dtq_pkg::ST_NONE_DUE, 31'd0, 31'd0, 1'b1};
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= dtq_pkg::CntW'(dtq_pkg::TableDepth))
        else $error("fill over depth");
    a_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("ready while busy");
    a_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status == dtq_pkg::ST_POSTED) |-> (o_rsp.assigned_id != 31'd0))
        else $error("zero id posted");
`endif

endmodule
